FILE: src/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg
// Shared widths, register indexes and job types of the plane slice unit.
// ----------------------------------------------------------------------------
package tps_pkg;

	localparam int COORD_W   = 32;
	localparam int FRAC_BITS = 16;
	localparam int NORM_W    = 18;
	localparam int PROD_W    = NORM_W + COORD_W;
	// three products plus the shifted offset, with headroom
	localparam int DIST_W    = COORD_W + NORM_W + 3;
	localparam int MAG_W     = COORD_W + 1;
	localparam int REM_W     = DIST_W + 2;
	localparam int CNT_W     = $clog2(MAG_W + 1);
	localparam int IDX_W     = 3;

	localparam logic [IDX_W-1:0] REG_NX  = 3'd0;
	localparam logic [IDX_W-1:0] REG_NY  = 3'd1;
	localparam logic [IDX_W-1:0] REG_NZ  = 3'd2;
	localparam logic [IDX_W-1:0] REG_OFF = 3'd3;
	localparam logic [IDX_W-1:0] REG_CX  = 3'd4;
	localparam logic [IDX_W-1:0] REG_CY  = 3'd5;
	localparam logic [IDX_W-1:0] REG_CZ  = 3'd6;

	typedef struct packed {
		logic       is_vtx;
		logic [1:0] p;
		logic [1:0] n;
	} corner_t;

	typedef struct packed {
		logic [3:0][2:0][COORD_W-1:0] vtx;
		logic [3:0][DIST_W-1:0]       cdist;
		logic                         two_tri;
		corner_t [5:0]                cs;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

FILE: src/tetrahedron_plane_slice_unit.sv
// ----------------------------------------------------------------------------
// tetrahedron_plane_slice_unit
// Slices one tetrahedron by a configured plane and emits zero to two triangles.
// ----------------------------------------------------------------------------
// channel  direction  handshake               payload
// cfg      in         cfg_valid / cfg_ready   cfg_index, cfg_data
// in       in         in_valid / in_ready     vert0_x .. vert3_z
// out      out        out_valid / out_ready   tri_a_x .. tri_c_z, last_of_item
//
// the classifier forms each vertex distance as a product step and then a sum step
// each edge-crossing corner runs the three per-axis 33-step crossing dividers,
// a vertex corner loads the vertex itself; each triangle ends in an emit state
// a two-job queue lets the classifier run ahead while the sequencer stalls
// reset restores the normal to +z and clears offset and centroid
// ----------------------------------------------------------------------------
module tetrahedron_plane_slice_unit import tps_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [IDX_W-1:0]          cfg_index,
	input  logic [COORD_W-1:0]        cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [COORD_W-1:0] vert0_x,
	input  logic signed [COORD_W-1:0] vert0_y,
	input  logic signed [COORD_W-1:0] vert0_z,
	input  logic signed [COORD_W-1:0] vert1_x,
	input  logic signed [COORD_W-1:0] vert1_y,
	input  logic signed [COORD_W-1:0] vert1_z,
	input  logic signed [COORD_W-1:0] vert2_x,
	input  logic signed [COORD_W-1:0] vert2_y,
	input  logic signed [COORD_W-1:0] vert2_z,
	input  logic signed [COORD_W-1:0] vert3_x,
	input  logic signed [COORD_W-1:0] vert3_y,
	input  logic signed [COORD_W-1:0] vert3_z,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [COORD_W-1:0] tri_a_x,
	output logic signed [COORD_W-1:0] tri_a_y,
	output logic signed [COORD_W-1:0] tri_a_z,
	output logic signed [COORD_W-1:0] tri_b_x,
	output logic signed [COORD_W-1:0] tri_b_y,
	output logic signed [COORD_W-1:0] tri_b_z,
	output logic signed [COORD_W-1:0] tri_c_x,
	output logic signed [COORD_W-1:0] tri_c_y,
	output logic signed [COORD_W-1:0] tri_c_z,
	output logic                      last_of_item
);

	logic signed [NORM_W-1:0]     nx_q, ny_q, nz_q;
	logic signed [COORD_W-1:0]    off_q, cx_q, cy_q, cz_q;
	logic [3:0][2:0][COORD_W-1:0] in_vtx;
	logic [2:0][2:0][COORD_W-1:0] out_tri;
	job_t                         f_job, b_job;
	q_stat_t                      qs;
	logic                         push, pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nx_q  <= '0;
			ny_q  <= '0;
			nz_q  <= NORM_W'(1) <<< FRAC_BITS;
			off_q <= '0;
			cx_q  <= '0;
			cy_q  <= '0;
			cz_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_NX:  nx_q  <= cfg_data[NORM_W-1:0];
				REG_NY:  ny_q  <= cfg_data[NORM_W-1:0];
				REG_NZ:  nz_q  <= cfg_data[NORM_W-1:0];
				REG_OFF: off_q <= cfg_data;
				REG_CX:  cx_q  <= cfg_data;
				REG_CY:  cy_q  <= cfg_data;
				REG_CZ:  cz_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_vtx[0][0] = vert0_x;
	assign in_vtx[0][1] = vert0_y;
	assign in_vtx[0][2] = vert0_z;
	assign in_vtx[1][0] = vert1_x;
	assign in_vtx[1][1] = vert1_y;
	assign in_vtx[1][2] = vert1_z;
	assign in_vtx[2][0] = vert2_x;
	assign in_vtx[2][1] = vert2_y;
	assign in_vtx[2][2] = vert2_z;
	assign in_vtx[3][0] = vert3_x;
	assign in_vtx[3][1] = vert3_y;
	assign in_vtx[3][2] = vert3_z;

	tps_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_vtx       (in_vtx),
		.normal_x     (nx_q),
		.normal_y     (ny_q),
		.normal_z     (nz_q),
		.plane_offset (off_q),
		.qs           (qs),
		.push         (push),
		.job          (f_job)
	);

	tps_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (f_job),
		.pop    (pop),
		.rd_job (b_job),
		.qs     (qs)
	);

	tps_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (b_job),
		.qs         (qs),
		.pop        (pop),
		.centroid_x (cx_q),
		.centroid_y (cy_q),
		.centroid_z (cz_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_tri    (out_tri),
		.out_last   (last_of_item)
	);

	assign tri_a_x = out_tri[0][0];
	assign tri_a_y = out_tri[0][1];
	assign tri_a_z = out_tri[0][2];
	assign tri_b_x = out_tri[1][0];
	assign tri_b_y = out_tri[1][1];
	assign tri_b_z = out_tri[1][2];
	assign tri_c_x = out_tri[2][0];
	assign tri_c_y = out_tri[2][1];
	assign tri_c_z = out_tri[2][2];

	// classifier holds one tetrahedron at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("classifier took a second item while busy");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && qs.full))
		else $error("job pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qs.empty)
		else $error("job popped from an empty queue");

endmodule

FILE: src/tps_queue.sv
// ----------------------------------------------------------------------------
// tps_queue
// Two-entry job queue between the classifier and the triangle sequencer.
// ----------------------------------------------------------------------------
module tps_queue import tps_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  job_t    wr_job,
	input  logic    pop,
	output job_t    rd_job,
	output q_stat_t qs
);

	job_t       mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= wr_job;
	end

	assign rd_job   = mem[rd_ptr_q];
	assign qs.full  = (cnt_q == 2'd2);
	assign qs.empty = (cnt_q == 2'd0);

endmodule

FILE: src/tps_front.sv
// ----------------------------------------------------------------------------
// tps_front
// Takes a tetrahedron, forms the four plane distances and builds the job.
// ----------------------------------------------------------------------------
module tps_front import tps_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [3:0][2:0][COORD_W-1:0] in_vtx,
	input  logic signed [NORM_W-1:0]     normal_x,
	input  logic signed [NORM_W-1:0]     normal_y,
	input  logic signed [NORM_W-1:0]     normal_z,
	input  logic signed [COORD_W-1:0]    plane_offset,
	input  q_stat_t                      qs,
	output logic                         push,
	output job_t                         job
);

	logic                         busy_q, done_q, ph_q;
	logic [1:0]                   idx_q;
	logic [3:0][2:0][COORD_W-1:0] vtx_q;
	logic [3:0][DIST_W-1:0]       dist_q;
	logic signed [PROD_W-1:0]     prod_q [3];
	logic signed [DIST_W-1:0]     off_sh, sum;
	logic                         accept, emit, two;
	logic [2:0]                   np, nn, nz;
	logic [1:0]                   ps [4];
	logic [1:0]                   ns [4];
	logic [1:0]                   zs [4];
	corner_t [5:0]                cs;

	function automatic corner_t xc(input logic [1:0] p, input logic [1:0] n);
		xc = '{is_vtx: 1'b0, p: p, n: n};
	endfunction

	function automatic corner_t vc(input logic [1:0] n);
		vc = '{is_vtx: 1'b1, p: 2'd0, n: n};
	endfunction

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;
	assign off_sh   = DIST_W'(plane_offset) <<< FRAC_BITS;
	assign sum      = DIST_W'(prod_q[0]) + DIST_W'(prod_q[1]) + DIST_W'(prod_q[2]) - off_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ph_q   <= 1'b0;
			idx_q  <= 2'd0;
		end else if (accept) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			ph_q   <= 1'b0;
			idx_q  <= 2'd0;
		end else if (busy_q && !done_q) begin
			ph_q <= ~ph_q;
			if (ph_q) begin
				if (idx_q == 2'd3) done_q <= 1'b1;
				else idx_q <= idx_q + 2'd1;
			end
		end else if (done_q && (!emit || !qs.full)) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) vtx_q <= in_vtx;
		if (busy_q && !done_q) begin
			if (!ph_q) begin
				prod_q[0] <= normal_x * $signed(vtx_q[idx_q][0]);
				prod_q[1] <= normal_y * $signed(vtx_q[idx_q][1]);
				prod_q[2] <= normal_z * $signed(vtx_q[idx_q][2]);
			end else begin
				dist_q[idx_q] <= sum;
			end
		end
	end

	// sort vertices into sign classes, ascending index
	always_comb begin
		np = 3'd0;
		nn = 3'd0;
		nz = 3'd0;
		for (int i = 0; i < 4; i++) begin
			ps[i] = 2'd0;
			ns[i] = 2'd0;
			zs[i] = 2'd0;
		end
		for (int i = 0; i < 4; i++) begin
			if (dist_q[i][DIST_W-1]) begin
				ns[nn[1:0]] = 2'(i);
				nn = nn + 3'd1;
			end else if (dist_q[i] == '0) begin
				zs[nz[1:0]] = 2'(i);
				nz = nz + 3'd1;
			end else begin
				ps[np[1:0]] = 2'(i);
				np = np + 3'd1;
			end
		end
	end

	assign emit = (np != 3'd0) && (nn != 3'd0);
	assign two  = (np == 3'd2) && (nn == 3'd2);

	always_comb begin
		cs = '0;
		if (two) begin
			cs[0] = xc(ps[1], ns[1]);
			cs[1] = xc(ps[0], ns[1]);
			cs[2] = xc(ps[1], ns[0]);
			cs[3] = xc(ps[0], ns[0]);
			cs[4] = xc(ps[1], ns[0]);
			cs[5] = xc(ps[0], ns[1]);
		end else if (np == 3'd3) begin
			cs[0] = xc(ps[0], ns[0]);
			cs[1] = xc(ps[1], ns[0]);
			cs[2] = xc(ps[2], ns[0]);
		end else if (np == 3'd2) begin
			cs[0] = xc(ps[0], ns[0]);
			cs[1] = xc(ps[1], ns[0]);
			cs[2] = vc(zs[0]);
		end else if (nn == 3'd3) begin
			cs[0] = xc(ps[0], ns[0]);
			cs[1] = xc(ps[0], ns[1]);
			cs[2] = xc(ps[0], ns[2]);
		end else if (nn == 3'd2) begin
			cs[0] = xc(ps[0], ns[0]);
			cs[1] = xc(ps[0], ns[1]);
			cs[2] = vc(zs[0]);
		end else begin
			cs[0] = xc(ps[0], ns[0]);
			cs[1] = vc(zs[0]);
			cs[2] = vc(zs[1]);
		end
	end

	assign push        = done_q && emit && !qs.full;
	assign job.vtx     = vtx_q;
	assign job.cdist   = dist_q;
	assign job.two_tri = two;
	assign job.cs      = cs;

endmodule

FILE: src/tps_div.sv
// ----------------------------------------------------------------------------
// tps_div
// Edge crossing step unit: floor(mag * cp / den), one bit of mag a cycle.
// ----------------------------------------------------------------------------
module tps_div import tps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIST_W-1:0] cp,
	input  logic [DIST_W-1:0] den,
	input  logic [MAG_W-1:0]  mag,
	output logic [MAG_W-1:0]  q,
	output logic              done
);

	logic [CNT_W-1:0] cnt_q;
	logic [MAG_W-1:0] mag_q, q_q;
	logic [REM_W-1:0] r_q, cp_q, den_q, t, den2;
	logic [REM_W-1:0] r_nx;
	logic [1:0]       qb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (start) cnt_q <= CNT_W'(MAG_W);
		else if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
	end

	// remainder stays below den, so 2r + cp stays below 3 den
	always_comb begin
		den2 = den_q << 1;
		t    = (r_q << 1) + (mag_q[MAG_W-1] ? cp_q : '0);
		if (t >= den2) begin
			r_nx = t - den2;
			qb   = 2'd2;
		end else if (t >= den_q) begin
			r_nx = t - den_q;
			qb   = 2'd1;
		end else begin
			r_nx = t;
			qb   = 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mag;
			cp_q  <= REM_W'(cp);
			den_q <= REM_W'(den);
			r_q   <= '0;
			q_q   <= '0;
		end else if (cnt_q != '0) begin
			mag_q <= mag_q << 1;
			r_q   <= r_nx;
			q_q   <= (q_q << 1) + MAG_W'(qb);
		end
	end

	assign q    = q_q;
	assign done = (cnt_q == '0);

endmodule

FILE: src/tps_back.sv
// ----------------------------------------------------------------------------
// tps_back
// Triangle sequencer: walks the corners of a job and drives the result.
// ----------------------------------------------------------------------------
module tps_back import tps_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  job_t                         job,
	input  q_stat_t                      qs,
	output logic                         pop,
	input  logic signed [COORD_W-1:0]    centroid_x,
	input  logic signed [COORD_W-1:0]    centroid_y,
	input  logic signed [COORD_W-1:0]    centroid_z,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [2:0][2:0][COORD_W-1:0] out_tri,
	output logic                         out_last
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_SUM  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]                   st_q;
	logic                         tri_q;
	logic [1:0]                   cor_q;
	logic                         out_valid_q, out_last_q;
	job_t                         job_q;
	logic [2:0][COORD_W-1:0]      raw_q;
	logic [2:0][2:0][COORD_W-1:0] cor_v_q, out_q;
	logic signed [COORD_W-1:0]    cent [3];
	corner_t                      spec;
	logic [2:0]                   sel;
	logic                         start, load_out;
	logic [2:0]                   dv_done;
	logic [MAG_W-1:0]             dv_q [3];
	logic [MAG_W-1:0]             mag [3];
	logic signed [MAG_W-1:0]      d [3];
	logic signed [MAG_W:0]        raw_nx [3];
	logic signed [COORD_W:0]      s [3];
	logic [DIST_W-1:0]            cp, den;

	function automatic logic [COORD_W-1:0] sat(input logic signed [COORD_W:0] v);
		if (v[COORD_W] != v[COORD_W-1])
			sat = v[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
		else
			sat = v[COORD_W-1:0];
	endfunction

	assign cent[0] = centroid_x;
	assign cent[1] = centroid_y;
	assign cent[2] = centroid_z;

	assign sel  = tri_q ? 3'(cor_q) + 3'd3 : 3'(cor_q);
	assign spec = job_q.cs[sel];
	assign cp   = job_q.cdist[spec.p];
	assign den  = job_q.cdist[spec.p] - job_q.cdist[spec.n];

	assign start    = (st_q == ST_LOAD) && !spec.is_vtx;
	assign pop      = (st_q == ST_IDLE) && !qs.empty;
	assign load_out = (st_q == ST_EMIT) && (!out_valid_q || out_ready);

	for (genvar k = 0; k < 3; k++) begin : g_axis
		assign d[k] = MAG_W'($signed(job_q.vtx[spec.n][k])) -
			MAG_W'($signed(job_q.vtx[spec.p][k]));
		assign mag[k] = d[k][MAG_W-1] ? MAG_W'(-d[k]) : MAG_W'(d[k]);
		// crossing moves from the positive vertex toward the negative one
		assign raw_nx[k] = (MAG_W+1)'($signed(job_q.vtx[spec.p][k])) +
			(d[k][MAG_W-1] ? -$signed({1'b0, dv_q[k]}) : $signed({1'b0, dv_q[k]}));
		assign s[k] = (COORD_W+1)'($signed(raw_q[k])) + (COORD_W+1)'(cent[k]);

		tps_div u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (start),
			.cp     (cp),
			.den    (den),
			.mag    (mag[k]),
			.q      (dv_q[k]),
			.done   (dv_done[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			tri_q       <= 1'b0;
			cor_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (pop) begin
						st_q  <= ST_LOAD;
						tri_q <= 1'b0;
						cor_q <= 2'd0;
					end
				end
				ST_LOAD: st_q <= spec.is_vtx ? ST_SUM : ST_DIV;
				ST_DIV:  if (dv_done[0]) st_q <= ST_SUM;
				ST_SUM: begin
					if (cor_q == 2'd2) st_q <= ST_EMIT;
					else begin
						cor_q <= cor_q + 2'd1;
						st_q  <= ST_LOAD;
					end
				end
				ST_EMIT: begin
					if (load_out) begin
						if (job_q.two_tri && !tri_q) begin
							tri_q <= 1'b1;
							cor_q <= 2'd0;
							st_q  <= ST_LOAD;
						end else begin
							st_q <= ST_IDLE;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) job_q <= job;
		for (int k = 0; k < 3; k++) begin
			if (st_q == ST_LOAD && spec.is_vtx) raw_q[k] <= job_q.vtx[spec.n][k];
			if (st_q == ST_DIV && dv_done[0]) raw_q[k] <= raw_nx[k][COORD_W-1:0];
			if (st_q == ST_SUM) cor_v_q[cor_q][k] <= sat(s[k]);
		end
		if (load_out) begin
			out_q      <= cor_v_q;
			out_last_q <= tri_q || !job_q.two_tri;
		end
	end

	assign out_valid = out_valid_q;
	assign out_tri   = out_q;
	assign out_last  = out_last_q;

endmodule
